FILE: design/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg: shared definitions for the PID position motor drive
// Widths, fixed-point constants, register indexes and the gain bundle used
// by the configuration block, the shared multiplier and the top level.
// ----------------------------------------------------------------------------
package pdm_pkg;

  // Position and error widths.
  localparam int POS_W   = 32;
  localparam int ERR_W   = POS_W + 1;
  localparam int DIF_W   = POS_W + 2;
  localparam int SUM_W   = 48;

  // Gains are signed Q8.8.
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 8;

  // Shared multiplier: gain times one 24-bit chunk of a 48-bit operand.
  localparam int CHUNK_W = 24;
  localparam int OPND_W  = 2 * CHUNK_W;
  localparam int MB_W    = CHUNK_W + 1;
  localparam int PROD_W  = GAIN_W + MB_W;
  localparam int TERM_W  = 64;

  // Effort and deadband widths.
  localparam int CLAMP_W = 18;
  localparam int EFF_W   = 10;
  localparam int DUTY_W  = 9;
  localparam int DB_FRAC = FRAC_W + 8;
  localparam int DB_W    = 27;

  // Stream and configuration widths.
  localparam int IN_DATA_W  = 2 * POS_W;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  // Fixed-point constants.
  localparam int EFF_LIMIT  = 400;
  localparam int POS_OFFSET = 138;
  localparam int NEG_OFFSET = 140;
  localparam int POS_SLOPE  = 168;
  localparam int NEG_SLOPE  = 166;

  localparam logic signed [TERM_W-1:0] TERM_MAX = 64'sh2000_0000_0000_0000;
  localparam logic signed [TERM_W-1:0] TERM_MIN = -64'sh2000_0000_0000_0000;
  localparam logic signed [TERM_W-1:0] EFF_MAX  = TERM_W'(EFF_LIMIT * (2 ** FRAC_W));
  localparam logic signed [TERM_W-1:0] EFF_MIN  = -TERM_W'(EFF_LIMIT * (2 ** FRAC_W));
  localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [DB_W-1:0]   POS_OFS_Q = DB_W'(POS_OFFSET * (2 ** DB_FRAC));
  localparam logic signed [DB_W-1:0]   NEG_OFS_Q = -DB_W'(NEG_OFFSET * (2 ** DB_FRAC));
  localparam logic signed [GAIN_W-1:0] POS_SLOPE_G = GAIN_W'(POS_SLOPE);
  localparam logic signed [GAIN_W-1:0] NEG_SLOPE_G = GAIN_W'(NEG_SLOPE);

  // The three controller gains.
  typedef struct packed {
    logic signed [GAIN_W-1:0] p;
    logic signed [GAIN_W-1:0] i;
    logic signed [GAIN_W-1:0] d;
  } gains_t;

endpackage

FILE: design/pdm_cfg.sv
// ----------------------------------------------------------------------------
// pdm_cfg: gain registers
// Holds the proportional, integral and derivative gains written through the
// plain write port. Writes to an unused index are ignored.
// ----------------------------------------------------------------------------
module pdm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdm_pkg::GAIN_W-1:0]        cfg_data,
  output pdm_pkg::gains_t                   gains
);

  pdm_pkg::gains_t gains_r;
  pdm_pkg::gains_t gains_nxt;

  // Decode the write to one gain.
  always_comb begin
    gains_nxt = gains_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pdm_pkg::REG_GAIN_P: gains_nxt.p = cfg_data;
        pdm_pkg::REG_GAIN_I: gains_nxt.i = cfg_data;
        pdm_pkg::REG_GAIN_D: gains_nxt.d = cfg_data;
        default:             gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  assign gains = gains_r;

endmodule

FILE: design/pdm_mul.sv
// ----------------------------------------------------------------------------
// pdm_mul: shared signed multiplier
// One 16 x 25 bit signed multiplier with a registered product. The sequencer
// feeds it gain and operand chunks, and the deadband slope at the end.
// ----------------------------------------------------------------------------
module pdm_mul (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [pdm_pkg::GAIN_W-1:0]        a,
  input  logic signed [pdm_pkg::MB_W-1:0]          b,
  output logic signed [pdm_pkg::PROD_W-1:0]        p
);

  logic signed [pdm_pkg::PROD_W-1:0] p_r;
  logic signed [pdm_pkg::PROD_W-1:0] p_nxt;

  // Full-width signed product.
  always_comb begin
    p_nxt = p_r;
    if (en) begin
      p_nxt = pdm_pkg::PROD_W'(a) * pdm_pkg::PROD_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

FILE: design/pid_position_motor_drive.sv
// ----------------------------------------------------------------------------
// pid_position_motor_drive: PID position controller with deadband offset
// Forms a clamped PID effort from one control tick and maps it past the motor
// deadband into a PWM duty and a direction bit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) takes one control tick per item: the target and
//   the measured encoder count. The output channel (out_*) returns one item
//   per tick: duty, direction, the clamped effort and the compensated effort.
//   Gains are written through cfg_we / cfg_index / cfg_data while idle.
//   The shared multiplier runs two passes per PID term (three terms) plus one
//   pass for the deadband slope, each pass followed by an accumulate step.
//   in_tready is high only while the sequencer is idle.
//   The output register holds a finished item while the receiver stalls; the
//   next input item is still accepted and computed, and waits in the final
//   step until the output register is free.
//   Reset (rst_n low, synchronous) clears the gains, the error sum, the last
//   error and the output valid flag.
// ----------------------------------------------------------------------------
module pid_position_motor_drive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // target_position [31:0], measured_position [63:32]
  input  logic [pdm_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // duty [8:0], clockwise_dir [9], clamped_effort [19:10],
  // compensated_effort [29:20], zero fill [31:30]
  output logic [pdm_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pdm_pkg::GAIN_W-1:0]            cfg_data
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_TSUM  = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_DBM   = 4'd7;
  localparam logic [3:0] S_DBA   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [1:0] T_P = 2'd0;
  localparam logic [1:0] T_I = 2'd1;
  localparam logic [1:0] T_D = 2'd2;

  localparam int POS_W   = pdm_pkg::POS_W;
  localparam int ERR_W   = pdm_pkg::ERR_W;
  localparam int DIF_W   = pdm_pkg::DIF_W;
  localparam int SUM_W   = pdm_pkg::SUM_W;
  localparam int OPND_W  = pdm_pkg::OPND_W;
  localparam int CHUNK_W = pdm_pkg::CHUNK_W;
  localparam int MB_W    = pdm_pkg::MB_W;
  localparam int PROD_W  = pdm_pkg::PROD_W;
  localparam int TERM_W  = pdm_pkg::TERM_W;
  localparam int CLAMP_W = pdm_pkg::CLAMP_W;
  localparam int EFF_W   = pdm_pkg::EFF_W;
  localparam int DUTY_W  = pdm_pkg::DUTY_W;
  localparam int DB_W    = pdm_pkg::DB_W;
  localparam int DB_FRAC = pdm_pkg::DB_FRAC;
  localparam int FRAC_W  = pdm_pkg::FRAC_W;
  localparam int GAIN_W  = pdm_pkg::GAIN_W;

  // Control registers.
  logic [3:0]  state_r, state_nxt;
  logic [1:0]  term_r, term_nxt;
  logic        half_r, half_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Controller state.
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [ERR_W-1:0] prev_r, prev_nxt;

  // Per-item payload registers.
  logic signed [POS_W-1:0]   tgt_r, tgt_nxt;
  logic signed [POS_W-1:0]   meas_r, meas_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [DIF_W-1:0]   deriv_r, deriv_nxt;
  logic signed [TERM_W-1:0]  acc_r, acc_nxt;
  logic signed [TERM_W-1:0]  effort_r, effort_nxt;
  logic signed [CLAMP_W-1:0] clamped_r, clamped_nxt;
  logic signed [EFF_W-1:0]   cint_r, cint_nxt;
  logic [DUTY_W-1:0]         cmag_r, cmag_nxt;
  logic                      cneg_r, cneg_nxt;
  logic [pdm_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Datapath signals.
  pdm_pkg::gains_t           gains;
  logic                      mul_en;
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [GAIN_W-1:0]  gain_sel;
  logic signed [TERM_W-1:0]  prod_ext;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [TERM_W-1:0]  term_sat;
  logic [CLAMP_W-1:0]        cl_mag;
  logic [EFF_W-1:0]          cl_int_mag;
  logic signed [DB_W-1:0]    db_acc;
  logic [DB_W-1:0]           db_mag;
  logic [DB_W-DB_FRAC-1:0]   db_int;
  logic                      cl_neg;
  logic                      in_acc;
  logic                      out_free;

  pdm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  pdm_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cl_neg    = clamped_r[CLAMP_W-1];

  // Operand and gain of the current PID term.
  always_comb begin
    unique case (term_r)
      T_P: begin
        opnd     = OPND_W'(err_r);
        gain_sel = gains.p;
      end
      T_I: begin
        opnd     = OPND_W'(sum_r);
        gain_sel = gains.i;
      end
      T_D: begin
        opnd     = OPND_W'(deriv_r);
        gain_sel = gains.d;
      end
      default: begin
        opnd     = '0;
        gain_sel = '0;
      end
    endcase
  end

  // Multiplier inputs: a gain chunk pass, or the deadband slope pass.
  always_comb begin
    mul_en = (state_r == S_MUL) || (state_r == S_DBM);
    if (state_r == S_DBM) begin
      mul_a = cl_neg ? pdm_pkg::NEG_SLOPE_G : pdm_pkg::POS_SLOPE_G;
      mul_b = MB_W'(clamped_r);
    end else begin
      mul_a = gain_sel;
      if (half_r) begin
        mul_b = {opnd[OPND_W-1], opnd[OPND_W-1:CHUNK_W]};
      end else begin
        mul_b = {1'b0, opnd[CHUNK_W-1:0]};
      end
    end
  end

  // Saturating integral update and product sign extension.
  assign sum_ext  = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(err_r);
  assign prod_ext = TERM_W'(prod);

  // Each product term saturates at plus or minus 2^61.
  always_comb begin
    if (acc_r > pdm_pkg::TERM_MAX) begin
      term_sat = pdm_pkg::TERM_MAX;
    end else if (acc_r < pdm_pkg::TERM_MIN) begin
      term_sat = pdm_pkg::TERM_MIN;
    end else begin
      term_sat = acc_r;
    end
  end

  // Integer part of the clamped effort, truncated toward zero.
  assign cl_mag     = cl_neg ? CLAMP_W'(-clamped_r) : CLAMP_W'(clamped_r);
  assign cl_int_mag = EFF_W'(cl_mag[CLAMP_W-1:FRAC_W]);

  // Deadband offset plus slope, then truncation toward zero.
  assign db_acc = prod[DB_W-1:0] + (cl_neg ? pdm_pkg::NEG_OFS_Q : pdm_pkg::POS_OFS_Q);
  assign db_mag = db_acc[DB_W-1] ? DB_W'(-db_acc) : DB_W'(db_acc);
  assign db_int = db_mag[DB_W-1:DB_FRAC];

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    term_nxt      = term_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    tgt_nxt       = tgt_r;
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    deriv_nxt     = deriv_r;
    acc_nxt       = acc_r;
    effort_nxt    = effort_r;
    clamped_nxt   = clamped_r;
    cint_nxt      = cint_r;
    cmag_nxt      = cmag_r;
    cneg_nxt      = cneg_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tgt_nxt   = in_tdata[POS_W-1:0];
          meas_nxt  = in_tdata[2*POS_W-1:POS_W];
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        err_nxt   = ERR_W'(tgt_r) - ERR_W'(meas_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          sum_nxt = sum_ext[SUM_W] ? pdm_pkg::SUM_MIN : pdm_pkg::SUM_MAX;
        end else begin
          sum_nxt = sum_ext[SUM_W-1:0];
        end
        deriv_nxt  = DIF_W'(err_r) - DIF_W'(prev_r);
        prev_nxt   = err_r;
        effort_nxt = '0;
        term_nxt   = T_P;
        half_nxt   = 1'b0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (half_r) begin
          acc_nxt   = acc_r + (prod_ext <<< CHUNK_W);
          state_nxt = S_TSUM;
        end else begin
          acc_nxt   = prod_ext;
          half_nxt  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_TSUM: begin
        effort_nxt = effort_r + term_sat;
        half_nxt   = 1'b0;
        if (term_r == T_D) begin
          state_nxt = S_CLAMP;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_CLAMP: begin
        if (effort_r > pdm_pkg::EFF_MAX) begin
          clamped_nxt = CLAMP_W'(pdm_pkg::EFF_MAX);
        end else if (effort_r < pdm_pkg::EFF_MIN) begin
          clamped_nxt = CLAMP_W'(pdm_pkg::EFF_MIN);
        end else begin
          clamped_nxt = CLAMP_W'(effort_r);
        end
        state_nxt = S_DBM;
      end
      S_DBM: begin
        cint_nxt  = cl_neg ? EFF_W'(-cl_int_mag) : cl_int_mag;
        state_nxt = S_DBA;
      end
      S_DBA: begin
        // Zero effort bypasses the deadband offset.
        if (clamped_r == '0) begin
          cmag_nxt = '0;
        end else if (db_int > (DB_W - DB_FRAC)'(pdm_pkg::EFF_LIMIT)) begin
          cmag_nxt = DUTY_W'(pdm_pkg::EFF_LIMIT);
        end else begin
          cmag_nxt = DUTY_W'(db_int);
        end
        cneg_nxt  = cl_neg && (clamped_r != '0);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_data_nxt  = '0;
          out_data_nxt[DUTY_W-1:0]         = cmag_r;
          out_data_nxt[DUTY_W]             = cneg_r;
          out_data_nxt[DUTY_W+EFF_W:DUTY_W+1] = cint_r;
          out_data_nxt[DUTY_W+2*EFF_W:DUTY_W+EFF_W+1] =
            cneg_r ? EFF_W'(-{1'b0, cmag_r}) : EFF_W'({1'b0, cmag_r});
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and controller state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= T_P;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    meas_r     <= meas_nxt;
    err_r      <= err_nxt;
    deriv_r    <= deriv_nxt;
    acc_r      <= acc_nxt;
    effort_r   <= effort_nxt;
    clamped_r  <= clamped_nxt;
    cint_r     <= cint_nxt;
    cmag_r     <= cmag_nxt;
    cneg_r     <= cneg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // An accepted item starts the error step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ERR))
    else $error("accepted item did not start the sequence");

  // A finished item waits while the output register is still occupied.
  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result overwrote a stalled output item");

  // A term is summed only after both multiplier passes.
  a_term_halves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TSUM) |-> (half_r && $past(state_r) == S_ACC))
    else $error("term summed before both halves");

  // Duty stays within the PWM range.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[DUTY_W-1:0] <= DUTY_W'(pdm_pkg::EFF_LIMIT)))
    else $error("duty above limit");

  // Direction follows the sign of the compensated effort.
  a_dir_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[DUTY_W] == out_data_r[DUTY_W+2*EFF_W]))
    else $error("direction does not match effort sign");

endmodule
